// ----- rtl/core/cu_pkg.sv -----
// shared types and constants for the combination unranking block
`default_nettype none

package cu_pkg;

  localparam int MAX_N_DEF = 32;

  localparam int CFG_W     = 6;   // set_size, subset_size, element
  localparam int CFG_IDX_W = 1;
  localparam int RANK_W    = 30;
  localparam int BIN_W     = 30;  // holds C(32,16)
  localparam int ACC_W     = 32;
  localparam int POS_W     = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_SIZE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBSET_SIZE = 1'b1;

  localparam logic [CFG_W-1:0] SET_SIZE_RST    = 6'd4;
  localparam logic [CFG_W-1:0] SUBSET_SIZE_RST = 6'd2;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_CHK_RD,
    ST_CHK,
    ST_TRY_RD,
    ST_TRY,
    ST_LAST
  } cu_state_t;

  // read request into the binomial table
  typedef struct packed {
    logic             en;
    logic [CFG_W-1:0] row;
    logic [CFG_W-1:0] col;
  } cu_rd_req_t;

endpackage

`default_nettype wire

// ----- rtl/core/cu_binom_mem.sv -----
// binomial coefficient table, filled by pascal rule after reset
`default_nettype none

module cu_binom_mem #(
  parameter int MAX_N = cu_pkg::MAX_N_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire cu_pkg::cu_rd_req_t       rd_req,
  output logic [cu_pkg::BIN_W-1:0]      rd_data,
  output logic                          ready
);

  localparam int NW    = $clog2(MAX_N + 1);
  localparam int DEPTH = 1 << (2 * NW);
  localparam logic [NW-1:0] LAST_IDX = NW'(MAX_N);

  logic [cu_pkg::BIN_W-1:0] mem [DEPTH];

  logic                     fill_r;
  logic [NW-1:0]            fm_r, fj_r;
  logic                     p_v_r;
  logic [NW-1:0]            p_m_r, p_j_r;
  logic [cu_pkg::BIN_W-1:0] prev_r;
  logic [cu_pkg::BIN_W-1:0] rd_data_r;

  logic [2*NW-1:0]          rd_addr;
  logic                     rd_en;
  logic [2*NW-1:0]          wr_addr;
  logic [cu_pkg::BIN_W-1:0] wr_data;

  // fill reads row m-1 while row m is written
  assign rd_addr = fill_r ? {fm_r - NW'(1), fj_r}
                          : {rd_req.row[NW-1:0], rd_req.col[NW-1:0]};
  assign rd_en   = fill_r | rd_req.en;
  assign wr_addr = {p_m_r, p_j_r};

  always_comb begin
    if (p_m_r == '0) begin
      wr_data = (p_j_r == '0) ? cu_pkg::BIN_W'(1) : '0;
    end else if (p_j_r == '0) begin
      wr_data = rd_data_r;
    end else begin
      wr_data = rd_data_r + prev_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (p_v_r) begin
      mem[wr_addr] <= wr_data;
      prev_r       <= rd_data_r;
    end
    p_m_r <= fm_r;
    p_j_r <= fj_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 1'b1;
      fm_r   <= '0;
      fj_r   <= '0;
      p_v_r  <= 1'b0;
    end else begin
      p_v_r <= fill_r;
      if (fill_r) begin
        if (fj_r == LAST_IDX) begin
          fj_r <= '0;
          fm_r <= fm_r + NW'(1);
          if (fm_r == LAST_IDX) begin
            fill_r <= 1'b0;
          end
        end else begin
          fj_r <= fj_r + NW'(1);
        end
      end
    end
  end

  assign rd_data = rd_data_r;
  assign ready   = !fill_r && !p_v_r;

endmodule

`default_nettype wire

// ----- rtl/core/combination_unrank.sv -----
// combination unranking top level: control sequencer, config registers, result register
//
// turns a zero-based rank into the k elements (1-based, ascending) of the
// lexicographic combination at that rank among the k-subsets of {1..n}.
// a request is taken when start is high and busy is low; results then come
// out as one-cycle strobes on out_valid, element by element, with out_last
// on the final one. the receiver cannot stall: every result shows for
// exactly one cycle. k = 0, k > n, n = 0, n > MAX_N or rank >= C(n,k) give
// a single result with out_error set, element 0, position 0, last 1.
// after reset the binomial table is built by pascal rule, one entry a cycle,
// with busy high; config writes are taken during that time. a request ends
// soonest when n or k is out of range, later for a rank out of range or
// k = 1, and otherwise runs T candidate trials, where T < n is the number
// of trials: each trial is one table read plus one accumulate-and-compare,
// as the table memory read is registered. busy drops as the last result is
// registered, so the next request may start while that result is still on
// the ports.
`default_nettype none

module combination_unrank #(
  parameter int MAX_N = cu_pkg::MAX_N_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // request
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [cu_pkg::RANK_W-1:0]     in_rank,
  // results
  output logic                               out_valid,
  output logic [cu_pkg::CFG_W-1:0]           out_element,
  output logic [cu_pkg::POS_W-1:0]           out_position,
  output logic                               out_last,
  output logic                               out_error,
  // configuration
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [cu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cu_pkg::CFG_W-1:0]      cfg_data
);

  localparam int CW = cu_pkg::CFG_W;
  localparam int AW = cu_pkg::ACC_W;
  localparam int PW = cu_pkg::POS_W;

  cu_pkg::cu_state_t state_r, state_nxt;

  // configuration registers
  logic [CW-1:0] set_size_r, subset_size_r;

  // per-request working registers
  logic [CW-1:0]             n_r, n_nxt;
  logic [CW-1:0]             k_r, k_nxt;
  logic [cu_pkg::RANK_W-1:0] rank_r, rank_nxt;
  logic [AW-1:0]             acc_r, acc_nxt;
  logic [CW-1:0]             e_r, e_nxt;     // current candidate, then last chosen element
  logic [PW-1:0]             i_r, i_nxt;     // position being resolved

  // result register
  logic          out_valid_r, out_valid_nxt;
  logic [CW-1:0] out_element_r, out_element_nxt;
  logic [PW-1:0] out_position_r, out_position_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_error_r, out_error_nxt;

  // table port
  cu_pkg::cu_rd_req_t       rd_req;
  logic [cu_pkg::BIN_W-1:0] rd_data;
  logic                     tbl_ready;

  logic [AW-1:0] target;
  logic [AW-1:0] sum;
  logic          bad_size;

  cu_binom_mem #(
    .MAX_N (MAX_N)
  ) u_binom_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_req  (rd_req),
    .rd_data (rd_data),
    .ready   (tbl_ready)
  );

  assign target   = AW'(rank_r) + AW'(1);
  assign sum      = acc_r + AW'(rd_data);
  assign bad_size = (n_r == '0) || (n_r > CW'(MAX_N)) || (k_r == '0) || (k_r > n_r);

  // config writes land at any time; the block only reads them on start
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_size_r    <= cu_pkg::SET_SIZE_RST;
      subset_size_r <= cu_pkg::SUBSET_SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cu_pkg::CFG_SET_SIZE:    set_size_r    <= cfg_data;
        cu_pkg::CFG_SUBSET_SIZE: subset_size_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // state and strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cu_pkg::ST_FILL;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    n_r            <= n_nxt;
    k_r            <= k_nxt;
    rank_r         <= rank_nxt;
    acc_r          <= acc_nxt;
    e_r            <= e_nxt;
    i_r            <= i_nxt;
    out_element_r  <= out_element_nxt;
    out_position_r <= out_position_nxt;
    out_last_r     <= out_last_nxt;
    out_error_r    <= out_error_nxt;
  end

  always_comb begin
    state_nxt        = state_r;
    n_nxt            = n_r;
    k_nxt            = k_r;
    rank_nxt         = rank_r;
    acc_nxt          = acc_r;
    e_nxt            = e_r;
    i_nxt            = i_r;
    out_valid_nxt    = 1'b0;
    out_element_nxt  = out_element_r;
    out_position_nxt = out_position_r;
    out_last_nxt     = out_last_r;
    out_error_nxt    = out_error_r;
    rd_req.en        = 1'b0;
    rd_req.row       = n_r - e_r;
    rd_req.col       = k_r - CW'(i_r) - CW'(1);
    busy             = 1'b1;

    unique case (state_r)
      cu_pkg::ST_FILL: begin
        if (tbl_ready) begin
          state_nxt = cu_pkg::ST_IDLE;
        end
      end

      cu_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          // snapshot config with the request
          n_nxt     = set_size_r;
          k_nxt     = subset_size_r;
          rank_nxt  = in_rank;
          state_nxt = cu_pkg::ST_CHK_RD;
        end
      end

      cu_pkg::ST_CHK_RD: begin
        if (bad_size) begin
          out_valid_nxt    = 1'b1;
          out_element_nxt  = '0;
          out_position_nxt = '0;
          out_last_nxt     = 1'b1;
          out_error_nxt    = 1'b1;
          state_nxt        = cu_pkg::ST_IDLE;
        end else begin
          // fetch C(n,k) for the range check
          rd_req.en  = 1'b1;
          rd_req.row = n_r;
          rd_req.col = k_r;
          state_nxt  = cu_pkg::ST_CHK;
        end
      end

      cu_pkg::ST_CHK: begin
        if (rank_r >= rd_data) begin
          out_valid_nxt    = 1'b1;
          out_element_nxt  = '0;
          out_position_nxt = '0;
          out_last_nxt     = 1'b1;
          out_error_nxt    = 1'b1;
          state_nxt        = cu_pkg::ST_IDLE;
        end else if (k_r == CW'(1)) begin
          // single element: rank+1 directly
          out_valid_nxt    = 1'b1;
          out_element_nxt  = target[CW-1:0];
          out_position_nxt = '0;
          out_last_nxt     = 1'b1;
          out_error_nxt    = 1'b0;
          state_nxt        = cu_pkg::ST_IDLE;
        end else begin
          acc_nxt   = '0;
          e_nxt     = CW'(1);
          i_nxt     = '0;
          state_nxt = cu_pkg::ST_TRY_RD;
        end
      end

      cu_pkg::ST_TRY_RD: begin
        // fetch C(n-e, k-i-1) for the current candidate
        rd_req.en = 1'b1;
        state_nxt = cu_pkg::ST_TRY;
      end

      cu_pkg::ST_TRY: begin
        if ((sum < target) && (e_r < n_r)) begin
          // rank lies past all combinations starting with e here
          acc_nxt   = sum;
          e_nxt     = e_r + CW'(1);
          state_nxt = cu_pkg::ST_TRY_RD;
        end else begin
          // candidate chosen, acc stays as it was before this trial
          out_valid_nxt    = 1'b1;
          out_element_nxt  = e_r;
          out_position_nxt = i_r;
          out_last_nxt     = 1'b0;
          out_error_nxt    = 1'b0;
          if ((CW'(i_r) + CW'(2)) < k_r) begin
            i_nxt     = i_r + PW'(1);
            e_nxt     = e_r + CW'(1);
            state_nxt = cu_pkg::ST_TRY_RD;
          end else begin
            state_nxt = cu_pkg::ST_LAST;
          end
        end
      end

      cu_pkg::ST_LAST: begin
        // final element is an offset from the last chosen one
        out_valid_nxt    = 1'b1;
        out_element_nxt  = CW'(AW'(e_r) + target - acc_r);
        out_position_nxt = PW'(k_r - CW'(1));
        out_last_nxt     = 1'b1;
        out_error_nxt    = 1'b0;
        state_nxt        = cu_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = cu_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid    = out_valid_r;
  assign out_element  = out_element_r;
  assign out_position = out_position_r;
  assign out_last     = out_last_r;
  assign out_error    = out_error_r;

endmodule

`default_nettype wire
